>>> design/tgarle_pkg.sv
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgarle_pkg;

   // Default width of the pixel counter
   localparam int PIXEL_COUNT_WIDTH_DEF = 24;

   // Width of the total_pixels register
   localparam int TOTAL_WIDTH = 24;

   // Widest configuration register
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_PIXELS    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SWAP_RED_BLUE   = 2'd2;

   // Packet header coding
   localparam logic [7:0] RUN_FLAG = 8'h80;
   localparam logic [7:0] RUN_BIAS = 8'd127;

   // Reset values of the registers
   localparam logic [2:0]             BPP_RESET   = 3'd3;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_RESET = 24'd1;
   localparam logic                   SWAP_RESET  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_image;
   } req_item_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        image_done;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]             bytes_per_pixel;
      logic [TOTAL_WIDTH-1:0] total_pixels;
      logic                   swap_red_blue;
   } cfg_type;

endpackage : tgarle_pkg

`default_nettype wire

>>> design/tgarle_decode.sv
// ----------------------------------------------------------------------------
// tgarle_decode
// Packet and pixel decode state; one compressed byte per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_decode #(
   parameter int PIXEL_COUNT_WIDTH = tgarle_pkg::PIXEL_COUNT_WIDTH_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire tgarle_pkg::cfg_type    cfg,
   input  wire                         in_accept,
   input  wire tgarle_pkg::req_item_type in_item,
   output logic                        res_valid,
   output tgarle_pkg::rsp_item_type    res_item
);
   import tgarle_pkg::*;

   localparam int PCW = PIXEL_COUNT_WIDTH;

   logic                 expect_header_ff, expect_header_in;
   logic                 run_packet_ff, run_packet_in;
   logic [7:0]           left_ff, left_in;
   logic [1:0]           pos_ff, pos_in;
   logic [23:0]          asm_ff, asm_in;
   logic [PCW-1:0]       emitted_ff, emitted_in;
   logic                 complete_ff, complete_in;

   logic [PCW-1:0]       total_sat;
   logic [2:0]           size;
   logic                 cur_expect;
   logic                 cur_run;
   logic [7:0]           cur_left;
   logic [1:0]           cur_pos;
   logic [23:0]          cur_asm;
   logic [PCW-1:0]       cur_emitted;
   logic                 cur_complete;
   logic [PCW-1:0]       remaining;
   logic [7:0]           count;
   logic [31:0]          shifted;
   logic [31:0]          px;
   logic [7:0]           rep;
   logic [PCW:0]         sum;
   logic [PCW-1:0]       emitted_new;
   logic                 done;

   // Saturate the pixel total at the counter range
   generate
      if (TOTAL_WIDTH > PCW) begin : g_sat
         assign total_sat = (|cfg.total_pixels[TOTAL_WIDTH-1:PCW]) ?
                            {PCW{1'b1}} : cfg.total_pixels[PCW-1:0];
      end else begin : g_ext
         assign total_sat = PCW'(cfg.total_pixels);
      end
   endgenerate

   always_comb begin
      if (cfg.bytes_per_pixel == 3'd0) begin
         size = 3'd1;
      end else if (cfg.bytes_per_pixel > 3'd4) begin
         size = 3'd4;
      end else begin
         size = cfg.bytes_per_pixel;
      end
   end

   always_comb begin
      // start of image clears the image state before the byte is decoded
      cur_expect   = in_item.start_image | expect_header_ff;
      cur_run      = in_item.start_image ? 1'b0 : run_packet_ff;
      cur_left     = in_item.start_image ? 8'd0 : left_ff;
      cur_pos      = in_item.start_image ? 2'd0 : pos_ff;
      cur_asm      = in_item.start_image ? 24'd0 : asm_ff;
      cur_emitted  = in_item.start_image ? '0 : emitted_ff;
      cur_complete = in_item.start_image ? 1'b0 : complete_ff;

      expect_header_in = cur_expect;
      run_packet_in    = cur_run;
      left_in          = cur_left;
      pos_in           = cur_pos;
      asm_in           = cur_asm;
      emitted_in       = cur_emitted;
      complete_in      = cur_complete;

      remaining   = (cur_emitted < total_sat) ? (total_sat - cur_emitted) : '0;
      count       = ((in_item.data_byte & RUN_FLAG) != 8'd0) ?
                    (in_item.data_byte - RUN_BIAS) : (in_item.data_byte + 8'd1);
      shifted     = 32'(in_item.data_byte) << {cur_pos, 3'b000};
      px          = {8'd0, cur_asm} | shifted;
      rep         = 8'd1;
      sum         = '0;
      emitted_new = '0;
      done        = 1'b0;
      res_valid   = 1'b0;

      if (cur_complete) begin
         // drop bytes until the next image
      end else if (cur_expect) begin
         run_packet_in = (in_item.data_byte & RUN_FLAG) != 8'd0;
         if (remaining == '0) begin
            complete_in = 1'b1;
         end else begin
            left_in          = (PCW'(count) > remaining) ? remaining[7:0] : count;
            pos_in           = 2'd0;
            asm_in           = 24'd0;
            expect_header_in = 1'b0;
         end
      end else if (({1'b0, cur_pos} + 3'd1) < size) begin
         asm_in = px[23:0];
         pos_in = cur_pos + 2'd1;
      end else begin
         unique case (size)
            3'd1:    px = px & 32'h0000_00FF;
            3'd2:    px = px & 32'h0000_FFFF;
            3'd3:    px = px & 32'h00FF_FFFF;
            default: px = px;
         endcase
         if (size >= 3'd3 && cfg.swap_red_blue) begin
            px = {px[31:24], px[7:0], px[15:8], px[23:16]};
         end
         if (cur_run) begin
            rep     = cur_left;
            left_in = 8'd0;
         end else begin
            rep     = 8'd1;
            left_in = (cur_left > 8'd0) ? cur_left - 8'd1 : 8'd0;
         end
         sum         = {1'b0, cur_emitted} + (PCW + 1)'(rep);
         emitted_new = sum[PCW-1:0];
         done        = emitted_new >= total_sat;
         emitted_in  = emitted_new;
         if (done) begin
            complete_in = 1'b1;
         end
         if (left_in == 8'd0) begin
            expect_header_in = 1'b1;
         end
         pos_in    = 2'd0;
         asm_in    = 24'd0;
         res_valid = in_accept;
      end
   end

   assign res_item.pixel_value  = px;
   assign res_item.repeat_count = rep;
   assign res_item.image_done   = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         run_packet_ff    <= 1'b0;
         left_ff          <= 8'd0;
         pos_ff           <= 2'd0;
         asm_ff           <= 24'd0;
         emitted_ff       <= '0;
         complete_ff      <= 1'b0;
      end else if (in_accept) begin
         expect_header_ff <= expect_header_in;
         run_packet_ff    <= run_packet_in;
         left_ff          <= left_in;
         pos_ff           <= pos_in;
         asm_ff           <= asm_in;
         emitted_ff       <= emitted_in;
         complete_ff      <= complete_in;
      end
   end

endmodule : tgarle_decode

`default_nettype wire

>>> design/tgarle_out_buf.sv
// ----------------------------------------------------------------------------
// tgarle_out_buf
// Result register with one skid entry between decode and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgarle_out_buf (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         load,
   input  wire tgarle_pkg::rsp_item_type load_item,
   output logic                        full,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output tgarle_pkg::rsp_item_type    rsp_item
);
   import tgarle_pkg::*;

   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff;
   logic         out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_free) begin
         out_valid_in = skid_valid_ff || load;
         out_item_in  = skid_valid_ff ? skid_item_ff : load_item;
      end
      // park a new item while the result register is held
      skid_valid_in = skid_valid_ff ? !out_free : (load && !out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
      if (load && !out_free && !skid_valid_ff) begin
         skid_item_ff <= load_item;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule : tgarle_out_buf

`default_nettype wire

>>> design/tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// TGA run-length decoder: compressed bytes in, pixels with repeat counts out.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   req     | req_valid req_stall req_item   | one compressed byte per item
//   rsp     | rsp_valid rsp_stall rsp_item   | pixel, repeat count, image done
//   csr     | csr_write_en csr_index csr_..  | register writes, no read-back
//
// One byte is taken every cycle while req_stall is low; the packet/pixel state
// and the result logic sit between the req port and the result register, so a
// pixel's result is registered there (or in the skid entry) before it shows on rsp.
// Reset is synchronous: registers go to their reset values and the first byte
// is decoded as a packet header.
// A stall on rsp holds the result; the next result parks in a skid entry and
// req_stall rises only while that entry is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_unit #(
   parameter int PIXEL_COUNT_WIDTH = tgarle_pkg::PIXEL_COUNT_WIDTH_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire tgarle_pkg::req_item_type             req_item,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output tgarle_pkg::rsp_item_type                  rsp_item,
   input  wire                                       csr_write_en,
   input  wire [tgarle_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire [tgarle_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data
);
   import tgarle_pkg::*;

   cfg_type      cfg_ff;
   logic         req_accept;
   logic         res_valid;
   rsp_item_type res_item;
   logic         buf_full;

   // Configuration registers; writes to unused indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bytes_per_pixel <= BPP_RESET;
         cfg_ff.total_pixels    <= TOTAL_RESET;
         cfg_ff.swap_red_blue   <= SWAP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: cfg_ff.bytes_per_pixel <= csr_write_data[2:0];
            CSR_TOTAL_PIXELS:    cfg_ff.total_pixels    <= csr_write_data[TOTAL_WIDTH-1:0];
            CSR_SWAP_RED_BLUE:   cfg_ff.swap_red_blue   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Hold input while the skid entry is occupied
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !buf_full;

   tgarle_decode #(
      .PIXEL_COUNT_WIDTH(PIXEL_COUNT_WIDTH)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (req_accept),
      .in_item   (req_item),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   tgarle_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_item (res_item),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule : tga_rle_pixel_decoder_unit

`default_nettype wire
